// ===== src/spsc_pkg.sv =====
// ----------------------------------------------------------------------------
// spsc_pkg
// Shared constants for the pending-signal stack controller.
// ----------------------------------------------------------------------------
package spsc_pkg;

  localparam int NumSignalsDef = 32;
  localparam int SigKill       = 9;
  localparam int SigAlarm      = 14;
  localparam int NestMax       = 255;

  // operation codes
  localparam logic [2:0] OP_POST   = 3'd0;
  localparam logic [2:0] OP_QUERY  = 3'd1;
  localparam logic [2:0] OP_HANDLE = 3'd2;
  localparam logic [2:0] OP_RETURN = 3'd3;
  localparam logic [2:0] OP_SETACT = 3'd4;
  localparam logic [2:0] OP_ALARM  = 3'd5;

endpackage

// ===== src/signal_pending_stack_controller_top.sv =====
// ----------------------------------------------------------------------------
// signal_pending_stack_controller_top
// Per-process signal queue, handler nesting, action masks and one alarm.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid / in_stall): one operation per transaction with
//   op, signal_number, mask_value, time_sec, time_usec, alarm_seconds.
//   Output channel (out_valid / out_stall): one result per operation,
//   status and signal_out.
//   Config channel (cfg_valid / cfg_ready): writes process_mask; only
//   write while no operation is in flight.
// Timing:
//   A small sequencer walks the queue and the handling set one entry per
//   cycle through a single compare / mask-merge unit. Post, return, set
//   action mask and arm alarm go through the execute state straight to the
//   output register; query also merges the action masks and scans the
//   queue; handle searches the queue, then shifts later entries down.
//   One operation is processed at a time; in_stall is high meanwhile and
//   drops in the cycle after the result is taken.
// Reset: synchronous rst clears queue length, handling set, nesting counts,
//   action masks and the alarm; no clearing pass is needed.
// Stall: a result waits in the output register while out_stall is high;
//   the next operation is not taken until the result is delivered.
// ----------------------------------------------------------------------------
module signal_pending_stack_controller_top
  import spsc_pkg::*;
#(
  parameter int NUM_SIGNALS = NumSignalsDef
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [2:0]  op,
  input  logic [5:0]  signal_number,
  input  logic [31:0] mask_value,
  input  logic [31:0] time_sec,
  input  logic [19:0] time_usec,
  input  logic [31:0] alarm_seconds,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        status,
  output logic [5:0]  signal_out,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [31:0] cfg_data
);

  localparam int IW = $clog2(NUM_SIGNALS);
  localparam int CW = $clog2(NUM_SIGNALS + 1);
  // masks are 32 bits wide; widen when there are more signals
  localparam int XW = (NUM_SIGNALS > 32) ? NUM_SIGNALS : 32;
  localparam logic [XW-1:0] KILL_BIT = XW'(1) << (SigKill - 1);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_EXEC   = 3'd1;
  localparam logic [2:0] S_MERGE  = 3'd2;
  localparam logic [2:0] S_SCAN   = 3'd3;
  localparam logic [2:0] S_SEARCH = 3'd4;
  localparam logic [2:0] S_SHIFT  = 3'd5;
  localparam logic [2:0] S_OUT    = 3'd6;

  logic [2:0]  state;
  logic [2:0]  op_r;
  logic [5:0]  sig_r;
  logic [31:0] mval_r, tsec_r, asec_r;
  logic [19:0] tusec_r;
  logic [31:0] process_mask;

  // signal queue (stack), bounded at NUM_SIGNALS entries
  logic [5:0]  queue [NUM_SIGNALS];
  logic [CW-1:0] qlen;
  logic [NUM_SIGNALS-1:0] handling;
  logic [7:0]  nest [NUM_SIGNALS];
  logic [31:0] act [NUM_SIGNALS];
  logic [NUM_SIGNALS-1:0] act_valid;
  logic [31:0] alarm_delay, alarm_sec;
  logic [19:0] alarm_usec;

  logic [CW-1:0] idx;
  logic [NUM_SIGNALS-1:0] blocked;
  logic        res_status;
  logic [5:0]  res_sig;

  logic        sig_ok;
  logic [IW-1:0] sig_i;
  logic [NUM_SIGNALS-1:0] merge_ok;
  logic [NUM_SIGNALS-1:0] kill_mask;
  logic [31:0] dur;
  logic [IW-1:0] idx_i;
  logic [31:0] act_rd;
  logic [XW-1:0] pmask_ext;
  logic [XW-1:0] act_ext;
  logic [NUM_SIGNALS-1:0] blocked_merged;

  // scan test on the entry below idx
  logic [5:0] qprev;
  logic [NUM_SIGNALS-1:0] qprev_bit;
  logic qent_search_free;

  assign sig_ok     = (sig_r >= 6'd1) && ({26'd0, sig_r} <= 32'(NUM_SIGNALS));
  assign sig_i      = IW'(sig_r - 6'd1);
  assign merge_ok   = {1'b0, {(NUM_SIGNALS-1){1'b1}}};
  assign kill_mask  = KILL_BIT[NUM_SIGNALS-1:0];
  assign dur        = (tsec_r - alarm_sec) - ((tusec_r >= alarm_usec) ? 32'd0 : 32'd1);
  assign idx_i      = IW'(idx);
  assign act_rd     = act_valid[idx_i] ? act[idx_i] : 32'd0;
  assign pmask_ext  = XW'(process_mask);
  assign act_ext    = XW'(act_rd);

  // one action mask merged per cycle
  assign blocked_merged = handling[idx_i] ?
                          (blocked | (act_ext[NUM_SIGNALS-1:0] & merge_ok)) : blocked;

  assign qprev            = queue[IW'(idx - 1'b1)];
  assign qprev_bit        = NUM_SIGNALS'(1) << IW'(qprev - 6'd1);
  assign qent_search_free = (qprev >= 6'd1) && ((blocked & qprev_bit) == '0);

  assign in_stall  = (state != S_IDLE);
  assign cfg_ready = 1'b1;
  assign out_valid = (state == S_OUT);
  assign status    = res_status;
  assign signal_out = res_sig;

  // control sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      qlen         <= '0;
      handling     <= '0;
      act_valid    <= '0;
      alarm_delay  <= '0;
      alarm_sec    <= '0;
      alarm_usec   <= '0;
      process_mask <= '0;
      for (int k = 0; k < NUM_SIGNALS; k++) nest[k] <= 8'd0;
    end else begin
      if (cfg_valid) process_mask <= cfg_data;
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            op_r    <= op;
            sig_r   <= signal_number;
            mval_r  <= mask_value;
            tsec_r  <= time_sec;
            tusec_r <= time_usec;
            asec_r  <= alarm_seconds;
            state   <= S_EXEC;
          end
        end
        S_EXEC: begin
          res_status <= 1'b0;
          res_sig    <= 6'd0;
          state      <= S_OUT;
          case (op_r)
            OP_POST: begin
              if (!sig_ok || qlen == CW'(NUM_SIGNALS)) res_status <= 1'b1;
              else begin
                queue[IW'(qlen)] <= sig_r;
                qlen <= qlen + 1'b1;
              end
            end
            OP_QUERY: begin
              if (alarm_delay != 32'd0 && dur >= alarm_delay &&
                  qlen != CW'(NUM_SIGNALS) && NUM_SIGNALS >= SigAlarm) begin
                queue[IW'(qlen)] <= 6'(SigAlarm);
                qlen        <= qlen + 1'b1;
                alarm_delay <= 32'd0;
              end
              blocked <= pmask_ext[NUM_SIGNALS-1:0];
              idx     <= '0;
              state   <= S_MERGE;
            end
            OP_HANDLE: begin
              if (!sig_ok) res_status <= 1'b1;
              else begin
                idx   <= qlen;
                state <= S_SEARCH;
              end
            end
            OP_RETURN: begin
              if (!sig_ok || !handling[sig_i]) res_status <= 1'b1;
              else begin
                if (nest[sig_i] > 8'd0) nest[sig_i] <= nest[sig_i] - 8'd1;
                if (nest[sig_i] <= 8'd1) handling[sig_i] <= 1'b0;
              end
            end
            OP_SETACT: begin
              if (!sig_ok) res_status <= 1'b1;
              else begin
                act[sig_i]       <= mval_r;
                act_valid[sig_i] <= 1'b1;
              end
            end
            OP_ALARM: begin
              alarm_delay <= asec_r;
              alarm_sec   <= tsec_r;
              alarm_usec  <= tusec_r;
            end
            default: res_status <= 1'b1;
          endcase
        end
        // one action mask merged per cycle; kill is never blocked
        S_MERGE: begin
          if (idx == CW'(NUM_SIGNALS - 1)) begin
            blocked <= blocked_merged & ~kill_mask;
            idx     <= qlen;
            state   <= S_SCAN;
          end else begin
            blocked <= blocked_merged;
            idx     <= idx + 1'b1;
          end
        end
        // newest to oldest, one entry per cycle
        S_SCAN: begin
          if (idx == '0) state <= S_OUT;
          else begin
            idx <= idx - 1'b1;
            if (qent_search_free) begin
              res_sig <= qprev;
              state   <= S_OUT;
            end
          end
        end
        S_SEARCH: begin
          if (idx == '0) begin
            res_status <= 1'b1;
            state      <= S_OUT;
          end else if (queue[IW'(idx - 1'b1)] == sig_r) begin
            idx   <= idx - 1'b1;
            qlen  <= qlen - 1'b1;
            if (nest[sig_i] == 8'd0) handling[sig_i] <= 1'b1;
            if (nest[sig_i] != 8'(NestMax)) nest[sig_i] <= nest[sig_i] + 8'd1;
            state <= S_SHIFT;
          end else idx <= idx - 1'b1;
        end
        // shift later entries down one per cycle
        S_SHIFT: begin
          if (idx >= CW'(NUM_SIGNALS - 1)) begin
            queue[NUM_SIGNALS-1] <= 6'd0;
            state <= S_OUT;
          end else begin
            queue[idx_i] <= queue[IW'(idx + 1'b1)];
            idx <= idx + 1'b1;
          end
        end
        S_OUT: begin
          if (!out_stall) state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

// ===== src/spsc_checker.sv =====
// ----------------------------------------------------------------------------
// spsc_checker
// Port-level checks for the pending-signal stack controller.
// ----------------------------------------------------------------------------
module spsc_checker (
  input logic       clk,
  input logic       rst,
  input logic       in_valid,
  input logic       in_stall,
  input logic       out_valid,
  input logic       out_stall,
  input logic       status,
  input logic [5:0] signal_out
);

  // a result that waits holds its value
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(status) && $stable(signal_out))
    else $error("result changed while stalled");

  // no new transaction while a result is shown
  a_busy: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> in_stall)
    else $error("input taken while result pending");

  // accepted item gives no result in the next cycle
  a_lat: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> !out_valid)
    else $error("result too early");

  // a returned signal always comes with success status
  a_sig: assert property (@(posedge clk) disable iff (rst)
    out_valid && signal_out != 6'd0 |-> status == 1'b0)
    else $error("signal with error status");

endmodule

bind signal_pending_stack_controller_top spsc_checker u_spsc_checker (
  .clk(clk), .rst(rst), .in_valid(in_valid), .in_stall(in_stall),
  .out_valid(out_valid), .out_stall(out_stall), .status(status),
  .signal_out(signal_out)
);
